// File: rtl/calorimeter_hit_accumulator_core_defines.svh
// Assertion macros shared by the accumulator RTL.
`ifndef CALORIMETER_HIT_ACCUMULATOR_CORE_DEFINES_SVH
`define CALORIMETER_HIT_ACCUMULATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define CHA_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define CHA_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/chacc_pkg.sv
// Shared types and constants of the calorimeter hit accumulator.
`default_nettype none
package chacc_pkg;

   localparam int unsigned CHANNELS_DEF = 16384;
   localparam int unsigned CHAN_W       = 14;
   localparam int unsigned ENERGY_W     = 24;
   localparam int unsigned TIME_W       = 32;

   localparam logic [ENERGY_W-1:0] ENERGY_MAX  = '1;
   localparam logic [ENERGY_W-1:0] ENERGY_ZERO = '0;
   localparam logic [TIME_W-1:0]   TIME_INIT   = '1;

   localparam logic ACTION_ADD  = 1'b0;
   localparam logic ACTION_READ = 1'b1;

   typedef struct packed {
      logic                action;
      logic [CHAN_W-1:0]   channel;
      logic [ENERGY_W-1:0] deposit_energy;
      logic [TIME_W-1:0]   deposit_time;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0]   hit_channel;
      logic [ENERGY_W-1:0] hit_energy;
      logic [TIME_W-1:0]   hit_time;
   } rsp_type;

   typedef struct packed {
      logic write;
      logic emit;
   } upd_ctl_type;

endpackage
`default_nettype wire

// File: rtl/chacc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module chacc_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// File: rtl/chacc_clear.sv
// Post-reset sweep that writes the reset value into every channel entry.
`default_nettype none
module chacc_clear #(
   parameter int unsigned CHANNELS = chacc_pkg::CHANNELS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   output      logic                        busy,
   output      logic [$clog2(CHANNELS)-1:0] addr
);
   import chacc_pkg::*;

   localparam int unsigned ADDR_W = $clog2(CHANNELS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CHANNELS - 1);

   typedef enum logic [1:0] {
      CLR_SWEEP = 2'b01,
      CLR_DONE  = 2'b10
   } clr_state_type;

   clr_state_type     state_ff, state_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;

   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      case (state_ff)
         CLR_SWEEP: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LAST_ADDR) begin
               state_in = CLR_DONE;
            end
         end
         CLR_DONE: begin
            addr_in = addr_ff;
         end
         default: begin
            state_in = CLR_SWEEP;
            addr_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CLR_SWEEP;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
      end
   end

   assign busy = (state_ff == CLR_SWEEP);
   assign addr = addr_ff;
endmodule
`default_nettype wire

// File: rtl/chacc_update.sv
// Modify step: forwarding, saturating add, earliest time, readout clear and hit decision.
`default_nettype none
module chacc_update #(
   parameter int unsigned CHANNELS = chacc_pkg::CHANNELS_DEF
) (
   input  chacc_pkg::req_type                   item,
   input  wire logic                            in_range,
   input  wire logic [$clog2(CHANNELS)-1:0]     addr,
   input  wire logic [chacc_pkg::ENERGY_W-1:0]  rd_sum,
   input  wire logic [chacc_pkg::TIME_W-1:0]    rd_time,
   input  wire logic                            fwd_valid,
   input  wire logic [$clog2(CHANNELS)-1:0]     fwd_addr,
   input  wire logic [chacc_pkg::ENERGY_W-1:0]  fwd_sum,
   input  wire logic [chacc_pkg::TIME_W-1:0]    fwd_time,
   input  wire logic [chacc_pkg::ENERGY_W-1:0]  threshold,
   output chacc_pkg::upd_ctl_type               ctl,
   output      logic [chacc_pkg::ENERGY_W-1:0]  new_sum,
   output      logic [chacc_pkg::TIME_W-1:0]    new_time,
   output      logic [chacc_pkg::ENERGY_W-1:0]  cur_sum,
   output      logic [chacc_pkg::TIME_W-1:0]    cur_time
);
   import chacc_pkg::*;

   logic                fwd_hit;
   logic [ENERGY_W:0]   sum_ext;
   logic [ENERGY_W-1:0] sum_sat;

   assign fwd_hit  = fwd_valid && (fwd_addr == addr);
   assign cur_sum  = fwd_hit ? fwd_sum  : rd_sum;
   assign cur_time = fwd_hit ? fwd_time : rd_time;

   assign sum_ext = {1'b0, cur_sum} + {1'b0, item.deposit_energy};
   assign sum_sat = sum_ext[ENERGY_W] ? ENERGY_MAX : sum_ext[ENERGY_W-1:0];

   always_comb begin
      ctl      = '0;
      new_sum  = ENERGY_ZERO;
      new_time = TIME_INIT;
      case (item.action)
         ACTION_ADD: begin
            ctl.write = in_range && (item.deposit_energy != ENERGY_ZERO);
            new_sum   = sum_sat;
            new_time  = (item.deposit_time < cur_time) ? item.deposit_time : cur_time;
         end
         ACTION_READ: begin
            ctl.write = in_range;
            ctl.emit  = in_range && (cur_sum > threshold);
         end
         default: begin
            ctl = '0;
         end
      endcase
   end
endmodule
`default_nettype wire

// File: rtl/calorimeter_hit_accumulator_core.sv
// Top level of the calorimeter hit accumulator.
//
//  channel  direction  handshake          transaction
//  req      in         req_valid/stall    deposit or readout of one channel
//  rsp      out        rsp_valid/stall    one hit above threshold
//  csr      in         csr_valid/ready    energy_threshold write
//
// One item per cycle sustained while req_stall is low; read-modify-write through the
// RAM read port, last write forwarded so back-to-back items may hit one channel.
// After reset a clearing pass over every channel entry holds req_stall high.
// A readout hit that finds the rsp register full and stalled holds the
// modify stage and stalls req. csr_ready is always high.
`default_nettype none
`include "calorimeter_hit_accumulator_core_defines.svh"
module calorimeter_hit_accumulator_core #(
   parameter int unsigned CHANNELS = chacc_pkg::CHANNELS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_stall,
   input  chacc_pkg::req_type                  req_data,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   output chacc_pkg::rsp_type                  rsp_data,
   input  wire logic                           csr_valid,
   output      logic                           csr_ready,
   input  wire logic [chacc_pkg::ENERGY_W-1:0] csr_data
);
   import chacc_pkg::*;

   localparam int unsigned ADDR_W = $clog2(CHANNELS);

   logic                clr_busy;
   logic [ADDR_W-1:0]   clr_addr;

   logic                req_accept;
   logic [ADDR_W-1:0]   req_addr;

   logic                s1_valid_ff, s1_valid_in;
   req_type             s1_item_ff;
   logic [ADDR_W-1:0]   s1_addr_ff;
   logic                s1_in_range_ff;
   logic                s1_go;
   logic                s1_we;

   logic [ENERGY_W-1:0] thr_ff;

   logic                fwd_valid_ff;
   logic [ADDR_W-1:0]   fwd_addr_ff;
   logic [ENERGY_W-1:0] fwd_sum_ff;
   logic [TIME_W-1:0]   fwd_time_ff;

   logic [ENERGY_W-1:0] rd_sum;
   logic [TIME_W-1:0]   rd_time;
   upd_ctl_type         upd_ctl;
   logic [ENERGY_W-1:0] new_sum, cur_sum;
   logic [TIME_W-1:0]   new_time, cur_time;

   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [ENERGY_W-1:0] ram_wsum;
   logic [TIME_W-1:0]   ram_wtime;

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff;
   logic                rsp_free;

   chacc_clear #(.CHANNELS(CHANNELS)) u_clear (
      .clock (clock),
      .reset (reset),
      .busy  (clr_busy),
      .addr  (clr_addr)
   );

   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_go      = !upd_ctl.emit || rsp_free;
   assign req_stall  = clr_busy || (s1_valid_ff && !s1_go);
   assign req_accept = req_valid && !req_stall;
   assign req_addr   = ADDR_W'(req_data.channel);
   assign s1_we      = s1_valid_ff && s1_go && upd_ctl.write;

   assign ram_we    = clr_busy || s1_we;
   assign ram_waddr = clr_busy ? clr_addr : s1_addr_ff;
   assign ram_wsum  = clr_busy ? ENERGY_ZERO : new_sum;
   assign ram_wtime = clr_busy ? TIME_INIT : new_time;

   chacc_ram #(.WIDTH(ENERGY_W), .DEPTH(CHANNELS)) u_sum_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wsum),
      .rd_en   (req_accept),
      .rd_addr (req_addr),
      .rd_data (rd_sum)
   );

   chacc_ram #(.WIDTH(TIME_W), .DEPTH(CHANNELS)) u_time_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wtime),
      .rd_en   (req_accept),
      .rd_addr (req_addr),
      .rd_data (rd_time)
   );

   chacc_update #(.CHANNELS(CHANNELS)) u_update (
      .item      (s1_item_ff),
      .in_range  (s1_in_range_ff),
      .addr      (s1_addr_ff),
      .rd_sum    (rd_sum),
      .rd_time   (rd_time),
      .fwd_valid (fwd_valid_ff),
      .fwd_addr  (fwd_addr_ff),
      .fwd_sum   (fwd_sum_ff),
      .fwd_time  (fwd_time_ff),
      .threshold (thr_ff),
      .ctl       (upd_ctl),
      .new_sum   (new_sum),
      .new_time  (new_time),
      .cur_sum   (cur_sum),
      .cur_time  (cur_time)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_valid_ff && s1_go && upd_ctl.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_valid_ff <= 1'b0;
         thr_ff       <= ENERGY_ZERO;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_we) begin
            fwd_valid_ff <= 1'b1;
         end
         if (csr_valid) begin
            thr_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff     <= req_data;
         s1_addr_ff     <= req_addr;
         s1_in_range_ff <= (32'(req_data.channel) < CHANNELS);
      end
      if (s1_we) begin
         fwd_addr_ff <= s1_addr_ff;
         fwd_sum_ff  <= new_sum;
         fwd_time_ff <= new_time;
      end
      if (s1_valid_ff && s1_go && upd_ctl.emit) begin
         rsp_data_ff.hit_channel <= s1_item_ff.channel;
         rsp_data_ff.hit_energy  <= cur_sum;
         rsp_data_ff.hit_time    <= cur_time;
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `CHA_ASSERT_IMP(a_no_item_in_clear, clr_busy, !s1_valid_ff && req_stall, "item during clear")
   `CHA_ASSERT_IMP(a_no_write_in_clear, clr_busy, !s1_we, "modify write during clear")
   `CHA_ASSERT_NXT(a_s1_hold, s1_valid_ff && !s1_go,
      s1_valid_ff && $stable(s1_addr_ff) && $stable(rd_sum), "stalled stage lost its entry")
   `CHA_ASSERT_IMP(a_emit_is_readout, s1_valid_ff && upd_ctl.emit,
      s1_item_ff.action == ACTION_READ, "hit from a deposit")
endmodule
`default_nettype wire

// File: tb/calorimeter_hit_accumulator_core_monitor.sv
// Checker for the hit accumulator: mirrors the per-channel store and scores every hit transaction.
`default_nettype none
module calorimeter_hit_accumulator_core_monitor #(
   parameter int unsigned CHANNELS = chacc_pkg::CHANNELS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_stall,
   input  chacc_pkg::req_type                  req_data,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   input  chacc_pkg::rsp_type                  rsp_data,
   input  wire logic                           csr_valid,
   input  wire logic                           csr_ready,
   input  wire logic [chacc_pkg::ENERGY_W-1:0] csr_data,
   output int                                  hits_pending,
   output int                                  mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import chacc_pkg::*;

   logic [ENERGY_W-1:0] chan_energy     [CHANNELS];
   logic [TIME_W-1:0]   chan_first_time [CHANNELS];
   logic [ENERGY_W-1:0] hit_threshold;
   rsp_type             expected_hits   [$];
   int                  errors = 0;

   task automatic accumulate(input req_type item);
      logic [ENERGY_W:0] total;
      rsp_type           hit;
      if (item.channel >= CHANNELS) return;
      if (item.action == ACTION_ADD) begin
         if (item.deposit_energy == ENERGY_ZERO) return;
         total = chan_energy[item.channel] + item.deposit_energy;
         chan_energy[item.channel] = total[ENERGY_W] ? ENERGY_MAX : total[ENERGY_W-1:0];
         if (item.deposit_time < chan_first_time[item.channel]) begin
            chan_first_time[item.channel] = item.deposit_time;
         end
      end else begin
         if (chan_energy[item.channel] > hit_threshold) begin
            hit.hit_channel = item.channel;
            hit.hit_energy  = chan_energy[item.channel];
            hit.hit_time    = chan_first_time[item.channel];
            expected_hits   = {expected_hits, hit};
         end
         chan_energy[item.channel]     = ENERGY_ZERO;
         chan_first_time[item.channel] = TIME_INIT;
      end
   endtask

   task automatic check_hit(input rsp_type got);
      rsp_type want;
      if (expected_hits.size() == 0) begin
         $error("unexpected hit transaction: channel %0d energy %0d time %0d",
                got.hit_channel, got.hit_energy, got.hit_time);
         errors++;
         return;
      end
      want = expected_hits.pop_front();
      if (got.hit_channel !== want.hit_channel) begin
         $error("hit_channel: expected %0d, actual %0d", want.hit_channel, got.hit_channel);
         errors++;
      end
      if (got.hit_energy !== want.hit_energy) begin
         $error("hit_energy: expected %0d, actual %0d", want.hit_energy, got.hit_energy);
         errors++;
      end
      if (got.hit_time !== want.hit_time) begin
         $error("hit_time: expected %0d, actual %0d", want.hit_time, got.hit_time);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            chan_energy[i]     = ENERGY_ZERO;
            chan_first_time[i] = TIME_INIT;
         end
         hit_threshold = ENERGY_ZERO;
         expected_hits.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_hit(rsp_data);
         if (csr_valid && csr_ready) hit_threshold = csr_data;
         if (req_valid && !req_stall) accumulate(req_data);
      end
      hits_pending   <= expected_hits.size();
      mismatch_count <= errors;
   end

endmodule
`default_nettype wire

// File: tb/calorimeter_hit_accumulator_core_tb.sv
// Stimulus and verdict for the calorimeter hit accumulator core.
`default_nettype none
module calorimeter_hit_accumulator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import chacc_pkg::*;

   localparam int unsigned HOT_N           = 6;
   localparam int unsigned PHASES          = 6;
   localparam int unsigned PHASE_ITEMS     = 215;
   localparam int unsigned DRAIN_CYCLES    = 12;
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   localparam int unsigned CYCLE_LIMIT     = 400000;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   req_type             req_data  = '0;
   logic                rsp_stall = 1'b0;
   logic                csr_valid = 1'b0;
   logic [ENERGY_W-1:0] csr_data  = '0;
   logic                req_stall;
   logic                rsp_valid;
   rsp_type             rsp_data;
   logic                csr_ready;
   int                  hits_pending;
   int                  mismatch_count;
   bit                  gaps_on     = 1'b1;
   bit                  pressure_on = 1'b0;
   int unsigned         cycle_count = 0;
   logic [CHAN_W-1:0]   hot_chan [HOT_N];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   calorimeter_hit_accumulator_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   calorimeter_hit_accumulator_core_monitor monitor (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .hits_pending   (hits_pending),
      .mismatch_count (mismatch_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // hit receiver: random stalls, plus one long hold-off during the pressure phase
   initial begin
      bit held;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (pressure_on && !held) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            held = 1'b1;
         end
         rsp_stall <= gaps_on && ($urandom_range(0, 99) < 21);
      end
   end

   function automatic req_type deposit(input int unsigned ch, input logic [ENERGY_W-1:0] e,
                                       input logic [TIME_W-1:0] t);
      req_type item;
      item.action         = ACTION_ADD;
      item.channel        = CHAN_W'(ch);
      item.deposit_energy = e;
      item.deposit_time   = t;
      return item;
   endfunction

   function automatic req_type readout(input int unsigned ch);
      req_type item;
      item.action         = ACTION_READ;
      item.channel        = CHAN_W'(ch);
      item.deposit_energy = ENERGY_W'($urandom);
      item.deposit_time   = $urandom_range(0, 32'hFFFF_FFFE);
      return item;
   endfunction

   function automatic logic [ENERGY_W-1:0] random_energy();
      case ($urandom_range(0, 9))
         0, 1, 2:    return ENERGY_W'($urandom_range(1, 255));
         3, 4, 5, 6: return ENERGY_W'($urandom_range(1, 65535));
         7, 8:       return ENERGY_W'($urandom_range(1, 24'h7F_FFFF));
         default:    return ENERGY_W'($urandom_range(1, 24'hFF_FFFF));
      endcase
   endfunction

   function automatic void refresh_hot_channels();
      for (int i = 0; i < HOT_N; i++) begin
         case ($urandom_range(0, 19))
            0:       hot_chan[i] = '0;
            1:       hot_chan[i] = '1;
            default: hot_chan[i] = CHAN_W'($urandom);
         endcase
      end
   endfunction

   // mostly deposit/readout runs on a few hot channels, some stray and ignored items
   function automatic req_type random_event();
      req_type     item;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      item = deposit(hot_chan[$urandom_range(0, HOT_N - 1)], random_energy(),
                     $urandom_range(0, 32'hFFFF_FFFE));
      if (pick < 22) begin
         item = readout(item.channel);
      end else if (pick < 30) begin
         item.channel = CHAN_W'($urandom);
         if (pick < 26) item.action = ACTION_READ;
      end else if (pick < 33) begin
         item.deposit_energy = ENERGY_ZERO;
      end
      return item;
   endfunction

   task automatic send_item(input req_type item);
      if (gaps_on && $urandom_range(0, 99) < 21) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [ENERGY_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (hits_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [ENERGY_W-1:0] phase_threshold [PHASES];
      int unsigned         counted;
      req_type             item;
      phase_threshold = '{24'd0, ENERGY_MAX, 24'd1, 24'd6000000, 24'hFF_FFFE, 24'd0};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      write_threshold(ENERGY_ZERO);

      send_item(deposit(0, 24'd1, 32'd0));
      send_item(readout(0));
      send_item(deposit(16383, ENERGY_MAX, 32'hFFFF_FFFE));
      send_item(deposit(16383, 24'd5, 32'hFFFF_FFFE));
      send_item(readout(16383));
      send_item(deposit(5, ENERGY_ZERO, 32'd0));
      send_item(readout(5));
      send_item(deposit(7, 24'd100, 32'd500));
      send_item(deposit(7, 24'd200, 32'd700));
      send_item(deposit(7, 24'd1, 32'd300));
      send_item(readout(7));
      send_item(readout(7));
      send_item(deposit(9, 24'd10, 32'd1000));
      send_item(deposit(9, 24'd20, 32'd999));
      send_item(readout(9));
      send_item(readout(9));
      wait_idle();
      write_threshold(24'd300);
      send_item(deposit(3, 24'd300, 32'd10));
      send_item(readout(3));
      send_item(deposit(3, 24'd301, 32'd10));
      send_item(readout(3));
      send_item(deposit(3, 24'h55_5555, 32'h5555_5555));
      send_item(deposit(3, 24'hAA_AAAA, 32'hAAAA_AAAA));
      send_item(readout(3));

      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         if (p == PHASES - 1) phase_threshold[p] = ENERGY_W'($urandom_range(0, 20000));
         write_threshold(phase_threshold[p]);
         gaps_on     <= (p != 0);
         pressure_on <= (p == 2);
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            if (counted % 40 == 0) refresh_hot_channels();
            item = random_event();
            send_item(item);
            if (item.action == ACTION_READ || item.deposit_energy != ENERGY_ZERO) counted++;
         end
      end

      wait_idle();
      @(negedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
`default_nettype wire
